@@ hw/rtl/svpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// svpwm_pkg
// Types and constants shared by the SVPWM compare generator: payload structs,
// register index codes, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // Input item: voltage command (volts x256) and phase currents (mA)
  typedef struct packed {
    logic signed [15:0] v_alpha;
    logic signed [15:0] v_beta;
    logic signed [15:0] cur_a;
    logic signed [15:0] cur_b;
    logic signed [15:0] cur_c;
  } svpwm_in_t;

  // Result item: three phase compare values and the sector
  typedef struct packed {
    logic [15:0] cmp_a;
    logic [15:0] cmp_b;
    logic [15:0] cmp_c;
    logic [2:0]  sector;
  } svpwm_out_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgRecipBus    = 2'd0,
    CfgPwmPeriod   = 2'd1,
    CfgCompareMin  = 2'd2,
    CfgDeadTimeCmp = 2'd3
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  // Register reset values
  localparam logic [23:0] RecipBusRst   = 24'd87381;
  localparam logic [15:0] PwmPeriodRst  = 16'd34000;
  localparam logic [14:0] CompareMinRst = 15'd100;
  localparam logic [11:0] DeadTimeRst   = 12'd0;

  // sqrt(3) in Q30
  localparam logic signed [31:0] Sqrt3Q30 = 32'sd1859775393;

  // Current above which dead-time compensation applies (mA)
  localparam logic signed [15:0] CurThresh = 16'sd10;

  // Map of projection sign code {b2,b1,b0} to sector
  function automatic logic [2:0] sector_lookup(input logic [2:0] code);
    logic [2:0] sec;
    case (code)
      3'd0:    sec = 3'd0;
      3'd1:    sec = 3'd2;
      3'd2:    sec = 3'd6;
      3'd3:    sec = 3'd1;
      3'd4:    sec = 3'd4;
      3'd5:    sec = 3'd3;
      3'd6:    sec = 3'd5;
      default: sec = 3'd0;
    endcase
    return sec;
  endfunction

endpackage

@@ hw/rtl/svpwm_compare_generator_unit.sv @@
// ----------------------------------------------------------------------------
// svpwm_compare_generator_unit
// Seven-segment space vector PWM compare generator. Finds the sector of an
// alpha/beta vector, scales the X/Y/Z times by the bus gain, forms the
// small/medium/big times, maps them to phases, adds dead-time compensation
// and saturates each compare into [compare_min, pwm_period - compare_min].
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | in_valid_i/in_ready_o  | in_data_i  (svpwm_in_t)
//  out     | output    | out_valid_o/out_ready_i| out_data_o (svpwm_out_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  Eight register stages, one item per cycle when the output is not stalled.
//  The 34x31 gain multiplies set the stage depth.
//  Each stage holds its own valid bit and loads when it is empty or the
//  next stage loads, so bubbles close up under an output stall.
//  Reset clears the valid bits and loads the register reset values.
//  An item taken while recip_bus is zero is dropped and gives no result.
//  The config port is always ready and takes one write per cycle.
//
module svpwm_compare_generator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  svpwm_pkg::svpwm_in_t          in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output svpwm_pkg::svpwm_out_t         out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [svpwm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [svpwm_pkg::CfgDataW-1:0] cfg_data_i
);
  import svpwm_pkg::*;

  localparam int unsigned NumStages = 8;

  // Configuration registers
  logic [23:0] recip_bus_q;
  logic [15:0] pwm_period_q;
  logic [14:0] compare_min_q;
  logic [11:0] dead_time_q;

  // Pipeline control
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] en;

  // Gain M = (2 * period * recip) >> 8
  logic [40:0] gain_full;
  logic [32:0] gain_q;

  // Stage 0: squares, sqrt3 product, 3*va, current flags
  logic [30:0]        s0_sqa_q, s0_sqb_q;
  logic signed [15:0] s0_va_q, s0_vb_q;
  logic signed [47:0] s0_u_q;
  logic signed [17:0] s0_va3_q;
  logic [2:0]         s0_dflag_q;
  logic signed [31:0] sqa_full, sqb_full;
  logic signed [47:0] u_full;

  // Stage 1: sector and doubled projection numerators
  logic [2:0]         s1_sec_q;
  logic signed [49:0] s1_ndx_q, s1_ndy_q, s1_ndz_q;
  logic [2:0]         s1_dflag_q;
  logic [32:0]        three_a2;
  logic               sq_gt, sq_lt, g1, g2;
  logic               va_pos, va_neg, vb_neg, vb_pos;
  logic signed [47:0] va3_sh;

  // Stage 2: projections truncated to Q10
  logic [2:0]         s2_sec_q;
  logic signed [29:0] s2_dx_q, s2_dy_q, s2_dz_q;
  logic [2:0]         s2_dflag_q;

  // Stage 3: Tx+Ty and Tx-Ty at projection scale
  logic [2:0]         s3_sec_q;
  logic signed [30:0] s3_sum_q, s3_dif_q;
  logic [2:0]         s3_dflag_q;
  logic signed [29:0] txd, tyd;

  // Stage 4: gain products
  logic [2:0]         s4_sec_q;
  logic signed [63:0] s4_psum_q, s4_pdif_q;
  logic [2:0]         s4_dflag_q;
  logic signed [64:0] psum_full, pdif_full;

  // Stage 5: small/medium/big numerators
  logic [2:0]         s5_sec_q;
  logic signed [63:0] s5_nsm_q, s5_nmd_q, s5_nbg_q;
  logic [2:0]         s5_dflag_q;
  logic signed [63:0] base;

  // Stage 6: whole-count times
  logic [2:0]         s6_sec_q;
  logic signed [30:0] s6_sm_q, s6_md_q, s6_bg_q;
  logic [2:0]         s6_dflag_q;

  // Stage 7: output register
  svpwm_out_t         s7_out_q;
  logic signed [30:0] pa, pb, pc;
  logic signed [32:0] va_c, vb_c, vc_c, vzero;
  logic signed [32:0] sat_lo, sat_hi;
  logic signed [16:0] hi_raw;

  // Truncate toward zero: n / 2^20
  function automatic logic signed [29:0] trunc20(input logic signed [49:0] n);
    logic signed [29:0] q;
    q = n[49:20];
    if (n[49] && (n[19:0] != '0)) begin
      q = q + 30'sd1;
    end
    return q;
  endfunction

  // Truncate toward zero: n / 2^33
  function automatic logic signed [30:0] trunc33(input logic signed [63:0] n);
    logic signed [30:0] q;
    q = n[63:33];
    if (n[63] && (n[32:0] != '0)) begin
      q = q + 31'sd1;
    end
    return q;
  endfunction

  // Clamp into [lo, hi], upper bound wins
  function automatic logic [15:0] sat_cmp(input logic signed [32:0] v,
                                          input logic signed [32:0] lo,
                                          input logic signed [32:0] hi);
    logic signed [32:0] r;
    r = v;
    if (r < lo) begin
      r = lo;
    end
    if (r > hi) begin
      r = hi;
    end
    return r[15:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_bus_q   <= RecipBusRst;
      pwm_period_q  <= PwmPeriodRst;
      compare_min_q <= CompareMinRst;
      dead_time_q   <= DeadTimeRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgRecipBus:    recip_bus_q   <= cfg_data_i[23:0];
        CfgPwmPeriod:   pwm_period_q  <= cfg_data_i[15:0];
        CfgCompareMin:  compare_min_q <= cfg_data_i[14:0];
        CfgDeadTimeCmp: dead_time_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Register the gain every cycle from the current period and bus reciprocal
  assign gain_full = {pwm_period_q, 1'b0} * {17'b0, recip_bus_q};

  always_ff @(posedge clk_i) begin
    gain_q <= gain_full[40:8];
  end

  // --------------------------------------------------------------------------
  // Stage enables and valid bits
  // --------------------------------------------------------------------------
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  // Drop items while the bus reciprocal is zero
  always_comb begin
    valid_d[0] = in_valid_i && (recip_bus_q != '0);
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: squares, vb*sqrt3, 3*va, current thresholds
  // --------------------------------------------------------------------------
  assign sqa_full = in_data_i.v_alpha * in_data_i.v_alpha;
  assign sqb_full = in_data_i.v_beta * in_data_i.v_beta;
  assign u_full   = in_data_i.v_beta * Sqrt3Q30;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_sqa_q      <= sqa_full[30:0];
      s0_sqb_q      <= sqb_full[30:0];
      s0_va_q       <= in_data_i.v_alpha;
      s0_vb_q       <= in_data_i.v_beta;
      s0_u_q        <= u_full;
      s0_va3_q      <= {{2{in_data_i.v_alpha[15]}}, in_data_i.v_alpha}
                     + {in_data_i.v_alpha[15], in_data_i.v_alpha, 1'b0};
      s0_dflag_q[0] <= in_data_i.cur_a > CurThresh;
      s0_dflag_q[1] <= in_data_i.cur_b > CurThresh;
      s0_dflag_q[2] <= in_data_i.cur_c > CurThresh;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: exact sector test through squares, projection numerators
  // --------------------------------------------------------------------------
  assign three_a2 = {2'b0, s0_sqa_q} + {1'b0, s0_sqa_q, 1'b0};
  assign sq_gt    = three_a2 > {2'b0, s0_sqb_q};
  assign sq_lt    = {2'b0, s0_sqb_q} > three_a2;
  assign va_pos   = !s0_va_q[15] && (s0_va_q != '0);
  assign va_neg   = s0_va_q[15];
  assign vb_neg   = s0_vb_q[15];
  assign vb_pos   = !s0_vb_q[15] && (s0_vb_q != '0);

  // sqrt3*va > vb
  always_comb begin
    if (!va_neg && vb_neg) begin
      g1 = 1'b1;
    end else if (!va_pos && !vb_neg) begin
      g1 = 1'b0;
    end else if (va_pos) begin
      g1 = sq_gt;
    end else begin
      g1 = sq_lt;
    end
  end

  // -sqrt3*va > vb
  always_comb begin
    if (!va_pos && vb_neg) begin
      g2 = 1'b1;
    end else if (!va_neg && !vb_neg) begin
      g2 = 1'b0;
    end else if (va_neg) begin
      g2 = sq_gt;
    end else begin
      g2 = sq_lt;
    end
  end

  assign va3_sh = {s0_va3_q, 30'b0};

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_sec_q   <= sector_lookup({g2, g1, vb_pos});
      s1_ndx_q   <= {s0_u_q[47], s0_u_q, 1'b0};
      s1_ndy_q   <= {{2{va3_sh[47]}}, va3_sh} + {{2{s0_u_q[47]}}, s0_u_q};
      s1_ndz_q   <= {{2{s0_u_q[47]}}, s0_u_q} - {{2{va3_sh[47]}}, va3_sh};
      s1_dflag_q <= s0_dflag_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: truncate projections to Q10
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_sec_q   <= s1_sec_q;
      s2_dx_q    <= trunc20(s1_ndx_q);
      s2_dy_q    <= trunc20(s1_ndy_q);
      s2_dz_q    <= trunc20(s1_ndz_q);
      s2_dflag_q <= s1_dflag_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: pick Tx/Ty by sector, form sum and difference
  // --------------------------------------------------------------------------
  always_comb begin
    case (s2_sec_q)
      3'd1: begin
        txd = -s2_dz_q;
        tyd = s2_dx_q;
      end
      3'd2: begin
        txd = s2_dz_q;
        tyd = s2_dy_q;
      end
      3'd3: begin
        txd = s2_dx_q;
        tyd = -s2_dy_q;
      end
      3'd4: begin
        txd = -s2_dx_q;
        tyd = s2_dz_q;
      end
      3'd5: begin
        txd = -s2_dy_q;
        tyd = -s2_dz_q;
      end
      default: begin
        txd = s2_dy_q;
        tyd = -s2_dx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_sec_q   <= s2_sec_q;
      s3_sum_q   <= {txd[29], txd} + {tyd[29], tyd};
      s3_dif_q   <= {txd[29], txd} - {tyd[29], tyd};
      s3_dflag_q <= s2_dflag_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: scale by the gain
  // --------------------------------------------------------------------------
  assign psum_full = $signed({1'b0, gain_q}) * s3_sum_q;
  assign pdif_full = $signed({1'b0, gain_q}) * s3_dif_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_sec_q   <= s3_sec_q;
      s4_psum_q  <= psum_full[63:0];
      s4_pdif_q  <= pdif_full[63:0];
      s4_dflag_q <= s3_dflag_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: add to Ts in Q31
  // --------------------------------------------------------------------------
  assign base = {16'b0, pwm_period_q, 32'b0};

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_sec_q   <= s4_sec_q;
      s5_nsm_q   <= base - s4_psum_q;
      s5_nmd_q   <= base + s4_pdif_q;
      s5_nbg_q   <= base + s4_psum_q;
      s5_dflag_q <= s4_dflag_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: quarter and drop the fraction
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_sec_q   <= s5_sec_q;
      s6_sm_q    <= trunc33(s5_nsm_q);
      s6_md_q    <= trunc33(s5_nmd_q);
      s6_bg_q    <= trunc33(s5_nbg_q);
      s6_dflag_q <= s5_dflag_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: map to phases, add dead time, saturate
  // --------------------------------------------------------------------------
  always_comb begin
    case (s6_sec_q)
      3'd1: begin
        pa = s6_sm_q;
        pb = s6_md_q;
        pc = s6_bg_q;
      end
      3'd2: begin
        pa = s6_md_q;
        pb = s6_sm_q;
        pc = s6_bg_q;
      end
      3'd3: begin
        pa = s6_bg_q;
        pb = s6_sm_q;
        pc = s6_md_q;
      end
      3'd4: begin
        pa = s6_bg_q;
        pb = s6_md_q;
        pc = s6_sm_q;
      end
      3'd5: begin
        pa = s6_md_q;
        pb = s6_bg_q;
        pc = s6_sm_q;
      end
      default: begin
        pa = s6_sm_q;
        pb = s6_bg_q;
        pc = s6_md_q;
      end
    endcase
  end

  assign hi_raw = $signed({1'b0, pwm_period_q}) - $signed({2'b0, compare_min_q});
  assign sat_lo = {18'b0, compare_min_q};
  assign sat_hi = hi_raw[16] ? 33'sd0 : {{16{hi_raw[16]}}, hi_raw};
  assign vzero  = {{16{hi_raw[16]}}, hi_raw};

  always_comb begin
    va_c = {{2{pa[30]}}, pa} + (s6_dflag_q[0] ? {21'b0, dead_time_q} : 33'sd0);
    vb_c = {{2{pb[30]}}, pb} + (s6_dflag_q[1] ? {21'b0, dead_time_q} : 33'sd0);
    vc_c = {{2{pc[30]}}, pc} + (s6_dflag_q[2] ? {21'b0, dead_time_q} : 33'sd0);
    // Undetermined vector: all phases at the upper bound
    if (s6_sec_q == 3'd0) begin
      va_c = vzero;
      vb_c = vzero;
      vc_c = vzero;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_out_q.cmp_a  <= sat_cmp(va_c, sat_lo, sat_hi);
      s7_out_q.cmp_b  <= sat_cmp(vb_c, sat_lo, sat_hi);
      s7_out_q.cmp_c  <= sat_cmp(vc_c, sat_lo, sat_hi);
      s7_out_q.sector <= s6_sec_q;
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign out_data_o  = s7_out_q;

endmodule

@@ tb/sv/svpwm_compare_generator_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_compare_generator_unit_test
// Self-checking bench for the SVPWM compare generator. A directed table walks
// the sector corners, the dead-time threshold, saturation edges and a zero
// bus. Random phases follow under changing register settings. Every result is
// checked field by field against a fixed-point predictor or a typed expected value.
// ----------------------------------------------------------------------------
module svpwm_compare_generator_unit_test;
  import svpwm_pkg::*;

  localparam int     LATENCY_GUARD = 12;
  localparam int     ERR_REPORTS   = 10;
  localparam longint CUR_LIMIT_MA  = 10;
  localparam longint SQRT3_Q30     = 64'sd1859775393;
  localparam longint Q20           = 64'sd1048576;
  localparam longint Q30           = 64'sd1073741824;
  localparam longint Q31           = 64'sd2147483648;
  localparam longint QUARTER_Q31   = 64'sd8589934592;
  localparam logic [2:0] SECTOR_OF_CODE [8] =
    '{3'd0, 3'd2, 3'd6, 3'd1, 3'd4, 3'd3, 3'd5, 3'd0};

  typedef enum {RowPredict, RowTyped, RowSilent, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    svpwm_in_t   item;
    svpwm_out_t  typed;
    cfg_reg_e    reg_idx;
    logic [23:0] reg_val;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  svpwm_in_t   in_data;
  logic        out_valid;
  logic        out_ready;
  svpwm_out_t  out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // Register copies used by the predictor
  logic [23:0] cfg_recip;
  logic [15:0] cfg_period;
  logic [14:0] cfg_cmp_min;
  logic [11:0] cfg_dead;

  svpwm_out_t pending_compares[$];
  svpwm_out_t head_compare;
  int         mismatch_count;
  bit         steady;
  int         ready_hold;
  int         stall;

  svpwm_compare_generator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Exact test of sqrt3*a > b
  function automatic bit sqrt3_exceeds(input longint a, input longint b);
    if (a >= 0 && b < 0) return 1'b1;
    if (a <= 0 && b >= 0) return 1'b0;
    if (a > 0) return 3 * a * a > b * b;
    return b * b > 3 * a * a;
  endfunction

  // Saturate into [min, period - min]; the upper bound wins when they cross
  function automatic logic [15:0] clamp_compare(input longint t);
    longint lo;
    longint hi;
    lo = longint'(cfg_cmp_min);
    hi = longint'(cfg_period) - longint'(cfg_cmp_min);
    if (hi < 0) hi = 0;
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    return t[15:0];
  endfunction

  function automatic bit predict_compares(input svpwm_in_t v, output svpwm_out_t r);
    longint va, vb, ts, gain, u, dx, dy, dz, x, y, z, tx, ty, base;
    longint t_small, t_mid, t_big, pa, pb, pc, dead;
    logic [2:0] code;
    logic [2:0] sec;
    r = '0;
    if (cfg_recip == 24'd0) return 1'b0;

    va = longint'($signed(v.v_alpha));
    vb = longint'($signed(v.v_beta));
    code = {sqrt3_exceeds(-va, vb), sqrt3_exceeds(va, vb), vb > 0};
    sec = SECTOR_OF_CODE[code];

    // Zero vector parks all phases at the upper bound
    if (sec == 3'd0) begin
      r.cmp_a  = clamp_compare(longint'(cfg_period) - longint'(cfg_cmp_min));
      r.cmp_b  = r.cmp_a;
      r.cmp_c  = r.cmp_a;
      r.sector = 3'd0;
      return 1'b1;
    end

    // Scale the doubled projections by the bus gain
    ts   = 2 * longint'(cfg_period);
    gain = (ts * longint'(cfg_recip)) >>> 8;
    u    = vb * SQRT3_Q30;
    dx   = (2 * u) / Q20;
    dy   = (3 * va * Q30 + u) / Q20;
    dz   = (u - 3 * va * Q30) / Q20;
    x    = gain * dx;
    y    = gain * dy;
    z    = gain * dz;

    case (sec)
      3'd1:    begin tx = -z; ty = x;  end
      3'd2:    begin tx = z;  ty = y;  end
      3'd3:    begin tx = x;  ty = -y; end
      3'd4:    begin tx = -x; ty = z;  end
      3'd5:    begin tx = -y; ty = -z; end
      default: begin tx = y;  ty = -x; end
    endcase

    base    = ts * Q31;
    t_small = (base - tx - ty) / QUARTER_Q31;
    t_mid   = (base + tx - ty) / QUARTER_Q31;
    t_big   = (base + tx + ty) / QUARTER_Q31;

    // Map small/medium/big to the phases
    case (sec)
      3'd1:    begin pa = t_small; pb = t_mid;   pc = t_big;   end
      3'd2:    begin pa = t_mid;   pb = t_small; pc = t_big;   end
      3'd3:    begin pa = t_big;   pb = t_small; pc = t_mid;   end
      3'd4:    begin pa = t_big;   pb = t_mid;   pc = t_small; end
      3'd5:    begin pa = t_mid;   pb = t_big;   pc = t_small; end
      default: begin pa = t_small; pb = t_big;   pc = t_mid;   end
    endcase

    dead = longint'(cfg_dead);
    r.cmp_a  = clamp_compare(pa + ((longint'($signed(v.cur_a)) > CUR_LIMIT_MA) ? dead : 0));
    r.cmp_b  = clamp_compare(pb + ((longint'($signed(v.cur_b)) > CUR_LIMIT_MA) ? dead : 0));
    r.cmp_c  = clamp_compare(pc + ((longint'($signed(v.cur_c)) > CUR_LIMIT_MA) ? dead : 0));
    r.sector = sec;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] clamp16(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic svpwm_in_t make_vector(input int va, input int vb, input int ca,
                                            input int cb, input int cc);
    svpwm_in_t r;
    r.v_alpha = clamp16(va);
    r.v_beta  = clamp16(vb);
    r.cur_a   = clamp16(ca);
    r.cur_b   = clamp16(cb);
    r.cur_c   = clamp16(cc);
    return r;
  endfunction

  function automatic stim_row_t vec_row(input row_kind_e kind, input int va, input int vb,
                                        input int ca = 0, input int cb = 0, input int cc = 0,
                                        input int ea = 0, input int eb = 0, input int ec = 0,
                                        input int es = 0);
    stim_row_t r;
    r.kind         = kind;
    r.item         = make_vector(va, vb, ca, cb, cc);
    r.typed.cmp_a  = ea[15:0];
    r.typed.cmp_b  = eb[15:0];
    r.typed.cmp_c  = ec[15:0];
    r.typed.sector = es[2:0];
    r.reg_idx      = CfgRecipBus;
    r.reg_val      = '0;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input cfg_reg_e idx, input logic [23:0] val);
    stim_row_t r;
    r         = vec_row(RowWrite, 0, 0);
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int signed_rand(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic int random_current();
    case ($urandom_range(0, 3))
      0:       return signed_rand(32768);
      1:       return int'($urandom_range(4, 16));
      2:       return signed_rand(2000);
      default: return pick_extreme();
    endcase
  endfunction

  function automatic svpwm_in_t random_vector();
    int va;
    int vb;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        va = signed_rand(3500);
        vb = signed_rand(3500);
      end
      4, 5: begin
        va = signed_rand(32768);
        vb = signed_rand(32768);
      end
      6: begin
        // straddle a sector boundary
        va = signed_rand(15000);
        vb = (va * 1732 / 1000) * ($urandom_range(0, 1) ? 1 : -1) + signed_rand(3);
      end
      7: begin
        if ($urandom_range(0, 1)) begin
          va = 0;
          vb = signed_rand(32768);
        end else begin
          va = signed_rand(32768);
          vb = 0;
        end
      end
      8: begin
        va = signed_rand(8);
        vb = signed_rand(8);
      end
      default: begin
        va = pick_extreme();
        vb = pick_extreme();
      end
    endcase
    return make_vector(va, vb, random_current(), random_current(), random_current());
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  task automatic send_vector(input svpwm_in_t item, input row_kind_e kind,
                             input svpwm_out_t typed);
    int         gap;
    bit         gives;
    svpwm_out_t predicted;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    // Record what this transfer should produce
    gives = predict_compares(item, predicted);
    case (kind)
      RowTyped:  pending_compares.push_back(typed);
      RowSilent: ;
      default:   if (gives) pending_compares.push_back(predicted);
    endcase
  endtask

  // Hold input low until the pipeline is empty
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_compares.size() != 0) @(posedge clk);
    repeat (LATENCY_GUARD) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgRecipBus:   cfg_recip   = val[23:0];
      CfgPwmPeriod:  cfg_period  = val[15:0];
      CfgCompareMin: cfg_cmp_min = val[14:0];
      default:       cfg_dead    = val[11:0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if (out_ready) begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        ready_hold = stall - 1;
      end else begin
        ready_hold = $urandom_range(0, 6);
      end
    end else begin
      out_ready <= 1'b1;
      ready_hold = $urandom_range(0, 10);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_compares.size() == 0) begin
        if (mismatch_count < ERR_REPORTS)
          $display("%0t: unexpected result a=%0d b=%0d c=%0d sector=%0d", $time,
                   out_data.cmp_a, out_data.cmp_b, out_data.cmp_c, out_data.sector);
        mismatch_count++;
      end else begin
        head_compare = pending_compares.pop_front();
        if (out_data.cmp_a !== head_compare.cmp_a || out_data.cmp_b !== head_compare.cmp_b ||
            out_data.cmp_c !== head_compare.cmp_c ||
            out_data.sector !== head_compare.sector) begin
          if (mismatch_count < ERR_REPORTS)
            $display("%0t: mismatch expected a=%0d b=%0d c=%0d sector=%0d, ",
                     $time, head_compare.cmp_a, head_compare.cmp_b, head_compare.cmp_c,
                     head_compare.sector,
                     "got a=%0d b=%0d c=%0d sector=%0d",
                     out_data.cmp_a, out_data.cmp_b, out_data.cmp_c, out_data.sector);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    stim_row_t   plan[$];
    logic [23:0] s_recip;
    logic [15:0] s_period;
    logic [14:0] s_min;
    logic [11:0] s_dead;
    int          n_items;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CfgRecipBus;
    cfg_data       = '0;
    steady         = 1'b0;
    mismatch_count = 0;
    cfg_recip      = RecipBusRst;
    cfg_period     = PwmPeriodRst;
    cfg_cmp_min    = CompareMinRst;
    cfg_dead       = DeadTimeRst;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: sector corners under reset settings
    plan.push_back(vec_row(RowTyped, 0, 0, 0, 0, 0, 33900, 33900, 33900, 0));
    plan.push_back(vec_row(RowPredict, 32767, 0));
    plan.push_back(vec_row(RowPredict, -32768, 0));
    plan.push_back(vec_row(RowPredict, 0, 32767));
    plan.push_back(vec_row(RowPredict, 0, -32768));
    plan.push_back(vec_row(RowPredict, 1000, 1000));
    plan.push_back(vec_row(RowPredict, -1000, 1000));
    plan.push_back(vec_row(RowPredict, 32767, 32767));
    plan.push_back(vec_row(RowPredict, -32768, -32768));
    plan.push_back(vec_row(RowPredict, 32767, -32768));
    plan.push_back(vec_row(RowPredict, -32768, 32767));
    plan.push_back(vec_row(RowPredict, 1, 0));
    // Dead time around the current threshold; zero vector ignores it
    plan.push_back(reg_row(CfgDeadTimeCmp, 24'd4095));
    plan.push_back(vec_row(RowPredict, 1500, 500, 10, 11, -32768));
    plan.push_back(vec_row(RowPredict, -700, -1200, 32767, 10, 11));
    plan.push_back(vec_row(RowTyped, 0, 0, 32767, 32767, 32767, 33900, 33900, 33900, 0));
    // Widest period, no minimum
    plan.push_back(reg_row(CfgPwmPeriod, 24'd65535));
    plan.push_back(reg_row(CfgCompareMin, 24'd0));
    plan.push_back(vec_row(RowTyped, 0, 0, 0, 0, 0, 65535, 65535, 65535, 0));
    plan.push_back(vec_row(RowPredict, 3000, -2000, 11, 11, 11));
    // Largest gain drives oversized times into saturation
    plan.push_back(reg_row(CfgRecipBus, 24'd16777215));
    plan.push_back(vec_row(RowPredict, 32767, 32767, -1, -1, -1));
    plan.push_back(vec_row(RowPredict, -32768, 0, 100, 100, 100));
    // Minimum beyond period: the upper bound collapses to zero
    plan.push_back(reg_row(CfgPwmPeriod, 24'd256));
    plan.push_back(reg_row(CfgCompareMin, 24'd32767));
    plan.push_back(vec_row(RowTyped, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(vec_row(RowPredict, 1200, -300, 11, 0, 0));
    // Crossed bounds: the upper one wins
    plan.push_back(reg_row(CfgCompareMin, 24'd200));
    plan.push_back(vec_row(RowTyped, 0, 0, 0, 0, 0, 56, 56, 56, 0));
    // Zero bus drops the item
    plan.push_back(reg_row(CfgRecipBus, 24'd0));
    plan.push_back(vec_row(RowSilent, 1000, 1000, 50, 50, 50));
    plan.push_back(vec_row(RowSilent, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].kind == RowWrite) begin
        drain_pipeline();
        write_register(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_vector(plan[i].item, plan[i].kind, plan[i].typed);
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin
          s_recip = RecipBusRst; s_period = PwmPeriodRst;
          s_min = CompareMinRst; s_dead = DeadTimeRst;
        end
        1: begin
          s_recip = 24'hFFFFFF; s_period = 16'hFFFF; s_min = 15'd0; s_dead = 12'hFFF;
        end
        2: begin
          s_recip = 24'd1; s_period = 16'd256; s_min = 15'd0; s_dead = 12'hFFF;
        end
        3: begin
          s_recip = 24'($urandom_range(1, 24'hFFFFFF)); s_period = 16'd300;
          s_min = 15'h7FFF; s_dead = 12'($urandom_range(0, 4095));
        end
        4: begin
          s_recip = 24'($urandom_range(20000, 300000));
          s_period = 16'($urandom_range(0, 255));
          s_min = 15'($urandom_range(0, 127)); s_dead = 12'($urandom_range(0, 4095));
        end
        5: begin
          s_recip = 24'd0; s_period = 16'($urandom_range(256, 65535));
          s_min = 15'($urandom_range(0, 2000)); s_dead = 12'($urandom_range(0, 4095));
        end
        default: begin
          s_recip = $urandom_range(0, 1) ? 24'($urandom_range(20000, 300000))
                                         : 24'($urandom_range(1, 24'hFFFFFF));
          s_period = 16'($urandom_range(256, 65535));
          s_min = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                               : 15'($urandom_range(0, 2000));
          s_dead = 12'($urandom_range(0, 4095));
        end
      endcase

      // Settle before touching the registers
      drain_pipeline();
      steady = (p % 4 == 2);
      write_register(CfgRecipBus, s_recip);
      write_register(CfgPwmPeriod, {8'd0, s_period});
      write_register(CfgCompareMin, {9'd0, s_min});
      write_register(CfgDeadTimeCmp, {12'd0, s_dead});

      n_items = (p == 5) ? 20 : 45;
      repeat (n_items) send_vector(random_vector(), RowPredict, '0);
    end

    // Wait out the tail and report
    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
